@@ rtl/core/adc_offset_decimating_averager_core_defines.svh @@
// Assertion macros shared by the checker of the offset/decimating averager.
// No dependencies; included by files that carry assertions.
`ifndef ADC_OFFSET_DECIMATING_AVERAGER_CORE_DEFINES_SVH
`define ADC_OFFSET_DECIMATING_AVERAGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADCODA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define ADCODA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

// Next-cycle implication that also holds across reset.
`define ADCODA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: reset check");

`endif

@@ rtl/core/adcoda_pkg.sv @@
// Shared types and constants for the ADC offset / decimating averager.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package adcoda_pkg;

    localparam int DATA_W     = 16;
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OFFSET_CH1 = 2'd0,
        REG_OFFSET_CH2 = 2'd1
    } cfg_reg_e;

    typedef struct packed {
        logic signed [DATA_W-1:0] raw_ch1;
        logic signed [DATA_W-1:0] raw_ch2;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] corrected_ch2;
        logic                     decim_valid;
        logic signed [DATA_W-1:0] decim_sample;
        logic                     mean_valid;
        logic signed [DATA_W-1:0] mean_ch1;
        logic signed [DATA_W-1:0] mean_ch2;
    } out_word_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] sample;
    } decim_res_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] mean_ch1;
        logic signed [DATA_W-1:0] mean_ch2;
    } mean_res_t;

endpackage

@@ rtl/core/adcoda_decimator.sv @@
// Two-stage boxcar decimator for corrected channel one.
// Depends on adcoda_pkg.
`timescale 1ns / 1ps

module adcoda_decimator #(
    parameter int FIRST_DECIM_LOG2  = 2,
    parameter int SECOND_DECIM_LOG2 = 5
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,
    input  logic signed [adcoda_pkg::DATA_W-1:0]  sample,
    output adcoda_pkg::decim_res_t                res
);

    localparam int FW = adcoda_pkg::DATA_W + FIRST_DECIM_LOG2;
    localparam int SW = adcoda_pkg::DATA_W + SECOND_DECIM_LOG2;

    logic signed [FW-1:0]                    sum4_reg, sum4_next, sum4_add;
    logic        [FIRST_DECIM_LOG2-1:0]      cnt4_reg, cnt4_next;
    logic signed [SW-1:0]                    summ_reg, summ_next, summ_add;
    logic        [SECOND_DECIM_LOG2-1:0]     cntm_reg, cntm_next;
    logic signed [adcoda_pkg::DATA_W-1:0]    block_mean;

    always_comb begin
        sum4_add   = sum4_reg + FW'(sample);
        block_mean = adcoda_pkg::DATA_W'(sum4_add >>> FIRST_DECIM_LOG2);
        summ_add   = summ_reg + SW'(block_mean);

        sum4_next = sum4_add;
        cnt4_next = cnt4_reg + 1'b1;
        summ_next = summ_reg;
        cntm_next = cntm_reg;
        res       = '0;

        // block of the first stage closes: fold its mean into the second stage
        if (&cnt4_reg) begin
            sum4_next = '0;
            summ_next = summ_add;
            cntm_next = cntm_reg + 1'b1;
            if (&cntm_reg) begin
                summ_next  = '0;
                res.valid  = 1'b1;
                res.sample = adcoda_pkg::DATA_W'(summ_add >>> SECOND_DECIM_LOG2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum4_reg <= '0;
            cnt4_reg <= '0;
            summ_reg <= '0;
            cntm_reg <= '0;
        end else if (step) begin
            sum4_reg <= sum4_next;
            cnt4_reg <= cnt4_next;
            summ_reg <= summ_next;
            cntm_reg <= cntm_next;
        end
    end

endmodule

@@ rtl/core/adcoda_window_avg.sv @@
// Long-window block averager for both corrected channels.
// Depends on adcoda_pkg.
`timescale 1ns / 1ps

module adcoda_window_avg #(
    parameter int AVG_SHIFT = 27
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,
    input  logic signed [adcoda_pkg::DATA_W-1:0]  sample_ch1,
    input  logic signed [adcoda_pkg::DATA_W-1:0]  sample_ch2,
    output adcoda_pkg::mean_res_t                 res
);

    localparam int WW = adcoda_pkg::DATA_W + AVG_SHIFT;

    logic signed [WW-1:0]        sum1_reg, sum1_next, sum1_add;
    logic signed [WW-1:0]        sum2_reg, sum2_next, sum2_add;
    logic        [AVG_SHIFT-1:0] cnt_reg, cnt_next;

    always_comb begin
        sum1_add  = sum1_reg + WW'(sample_ch1);
        sum2_add  = sum2_reg + WW'(sample_ch2);
        sum1_next = sum1_add;
        sum2_next = sum2_add;
        cnt_next  = cnt_reg + 1'b1;
        res       = '0;

        // last word of the window: report the mean including it, then clear
        if (&cnt_reg) begin
            sum1_next    = '0;
            sum2_next    = '0;
            res.valid    = 1'b1;
            res.mean_ch1 = adcoda_pkg::DATA_W'(sum1_add >>> AVG_SHIFT);
            res.mean_ch2 = adcoda_pkg::DATA_W'(sum2_add >>> AVG_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum1_reg <= '0;
            sum2_reg <= '0;
            cnt_reg  <= '0;
        end else if (step) begin
            sum1_reg <= sum1_next;
            sum2_reg <= sum2_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ rtl/core/adc_offset_decimating_averager_core.sv @@
// Top level of the ADC offset correction and decimating averager.
// Depends on adcoda_pkg, adcoda_decimator and adcoda_window_avg.
`timescale 1ns / 1ps

// One word in, one word out, at a sustained rate of one word per clock cycle
// while the output is not stalled. Each word passes through an input
// register and then a result register; the longest path is the long-window
// accumulator add (16 + AVG_SHIFT bits). Offsets are added with 16-bit
// wraparound. Channel one is averaged over 2^FIRST_DECIM_LOG2 words and then
// over 2^SECOND_DECIM_LOG2 of those block means (decim_valid once every 128
// words at the defaults); both channels are averaged over 2^AVG_SHIFT-word
// windows (mean_valid at each window end). Fields whose valid flag is low
// read as zero. Write offsets only while no word is in flight.
module adc_offset_decimating_averager_core #(
    parameter int AVG_SHIFT         = 27,
    parameter int FIRST_DECIM_LOG2  = 2,
    parameter int SECOND_DECIM_LOG2 = 5
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  adcoda_pkg::in_word_t                  s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output adcoda_pkg::out_word_t                 m_data,
    input  logic                                  cfg_wr_en,
    input  logic [adcoda_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [adcoda_pkg::DATA_W-1:0]         cfg_wdata
);

    logic                                  in_valid_reg, in_valid_next;
    adcoda_pkg::in_word_t                  in_data_reg;
    logic                                  out_valid_reg, out_valid_next;
    adcoda_pkg::out_word_t                 out_data_reg, out_data_next;
    logic signed [adcoda_pkg::DATA_W-1:0]  offset_ch1_reg, offset_ch2_reg;
    logic signed [adcoda_pkg::DATA_W-1:0]  corr_ch1, corr_ch2;
    logic                                  advance;
    adcoda_pkg::decim_res_t                decim_res;
    adcoda_pkg::mean_res_t                 mean_res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign corr_ch1 = in_data_reg.raw_ch1 + offset_ch1_reg;
    assign corr_ch2 = in_data_reg.raw_ch2 + offset_ch2_reg;

    adcoda_decimator #(
        .FIRST_DECIM_LOG2  (FIRST_DECIM_LOG2),
        .SECOND_DECIM_LOG2 (SECOND_DECIM_LOG2)
    ) u_decim (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .sample  (corr_ch1),
        .res     (decim_res)
    );

    adcoda_window_avg #(
        .AVG_SHIFT (AVG_SHIFT)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .sample_ch1 (corr_ch1),
        .sample_ch2 (corr_ch2),
        .res        (mean_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        out_data_next.corrected_ch2 = corr_ch2;
        out_data_next.decim_valid   = decim_res.valid;
        out_data_next.decim_sample  = decim_res.sample;
        out_data_next.mean_valid    = mean_res.valid;
        out_data_next.mean_ch1      = mean_res.mean_ch1;
        out_data_next.mean_ch2      = mean_res.mean_ch2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            offset_ch1_reg <= '0;
            offset_ch2_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (adcoda_pkg::cfg_reg_e'(cfg_addr))
                    adcoda_pkg::REG_OFFSET_CH1: begin
                        offset_ch1_reg <= cfg_wdata;
                    end
                    adcoda_pkg::REG_OFFSET_CH2: begin
                        offset_ch2_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ rtl/core/adcoda_checker.sv @@
// Port-level checker for the offset/decimating averager, bound to the top.
// Depends on adcoda_pkg and adc_offset_decimating_averager_core_defines.svh.
`timescale 1ns / 1ps
`include "adc_offset_decimating_averager_core_defines.svh"

module adcoda_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  adcoda_pkg::out_word_t  m_data
);

    // stalled result word holds
    `ADCODA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // decimated field reads zero unless flagged
    `ADCODA_ASSERT_NOW(a_decim_zero, aclk, aresetn, m_valid && !m_data.decim_valid, m_data.decim_sample == 16'sd0)

    // window means read zero unless flagged
    `ADCODA_ASSERT_NOW(a_mean_zero, aclk, aresetn, m_valid && !m_data.mean_valid, m_data.mean_ch1 == 16'sd0 && m_data.mean_ch2 == 16'sd0)

    // reset empties the pipeline: no result and room for a word
    `ADCODA_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind adc_offset_decimating_averager_core adcoda_checker u_adcoda_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
